// ===== hdl/gafm_pkg.sv =====
// Shared types, constants and helper functions for the grid A* first-move block.
// Used by gafm_heap and grid_astar_first_move through scoped names.
`timescale 1ns / 1ps
`default_nettype none

package gafm_pkg;

  localparam int GRID_SIDE = 32;
  localparam int COORD_W   = 5;
  localparam int CELL_W    = 2 * COORD_W;
  localparam int NCELLS    = GRID_SIDE * GRID_SIDE;
  localparam int G_W       = 10;
  localparam int H_W       = COORD_W + 1;
  localparam int F_W       = G_W + 1;
  localparam int SEQ_W     = 10;
  localparam int ENT_W     = F_W + SEQ_W + CELL_W;
  localparam int KEY_W     = F_W + SEQ_W;
  localparam int DIM_W     = 6;

  // Input operations.
  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_SEARCH  = 2'd2;
  localparam logic [1:0] OP_IGNORED = 2'd3;

  // Configuration register indexes.
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // Priority queue commands.
  localparam logic [1:0] HOP_PUSH = 2'd0;
  localparam logic [1:0] HOP_POP  = 2'd1;
  localparam logic [1:0] HOP_DEC  = 2'd2;
  localparam logic [1:0] HOP_CLR  = 2'd3;

  // Per-cell search marks.
  localparam logic [1:0] MK_UNSEEN = 2'd0;
  localparam logic [1:0] MK_OPEN   = 2'd1;
  localparam logic [1:0] MK_CLOSED = 2'd2;

  localparam logic [2:0] MOVE_NONE = 3'd4;

  // Heap entry: {f, insertion sequence, cell}. Comparing the upper KEY_W bits
  // orders by f first and insertion order second.
  typedef logic [ENT_W-1:0] heap_ent_t;

  typedef struct packed {
    logic             valid;
    logic [1:0]       op;
    heap_ent_t        entry;
    logic [CELL_W-1:0] cell_id;
  } heap_cmd_t;

  typedef struct packed {
    logic      busy;
    logic      done;
    logic      empty;
    heap_ent_t top;
  } heap_sts_t;

  function automatic logic [H_W-1:0] manhattan(input logic [COORD_W-1:0] ax,
                                              input logic [COORD_W-1:0] ay,
                                              input logic [COORD_W-1:0] bx,
                                              input logic [COORD_W-1:0] by);
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    dx = (ax > bx) ? (ax - bx) : (bx - ax);
    dy = (ay > by) ? (ay - by) : (by - ay);
    return {1'b0, dx} + {1'b0, dy};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/gafm_heap.sv =====
// Binary min-heap of open cells with decrease-key, held in block memories.
// One shared key comparator is stepped by a small sequencer. Uses gafm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gafm_heap (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire gafm_pkg::heap_cmd_t cmd,
  output gafm_pkg::heap_sts_t      sts
);

  localparam logic [3:0] H_IDLE   = 4'd0;
  localparam logic [3:0] H_SU_RD  = 4'd1;
  localparam logic [3:0] H_SU_CMP = 4'd2;
  localparam logic [3:0] H_P_RD   = 4'd3;
  localparam logic [3:0] H_P_LD   = 4'd4;
  localparam logic [3:0] H_SD_RD  = 4'd5;
  localparam logic [3:0] H_SD_SEL = 4'd6;
  localparam logic [3:0] H_SD_CMP = 4'd7;
  localparam logic [3:0] H_DK_RH  = 4'd8;
  localparam logic [3:0] H_DK_LD  = 4'd9;

  localparam int CW = gafm_pkg::CELL_W;
  localparam int EW = gafm_pkg::ENT_W;

  gafm_pkg::heap_ent_t heap_mem [gafm_pkg::NCELLS];
  logic [CW-1:0]       slot_mem [gafm_pkg::NCELLS];

  logic [3:0]          st_r, st_nxt;
  logic [CW:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]       pos_r, pos_nxt;
  logic [CW-1:0]       cpos_r, cpos_nxt;
  gafm_pkg::heap_ent_t ent_r, ent_nxt;
  gafm_pkg::heap_ent_t top_r, top_nxt;
  gafm_pkg::heap_ent_t child_r, child_nxt;
  logic                done_r, done_nxt;

  gafm_pkg::heap_ent_t rda_q, rdb_q;
  logic [CW-1:0]       rds_q;

  logic [CW-1:0]       ra, rb, wa;
  logic                we;
  gafm_pkg::heap_ent_t wd, cmp_a, cmp_b;
  logic                less;
  logic [CW-1:0]       par;
  logic [CW:0]         lch, rch;

  assign par  = (pos_r - CW'(1)) >> 1;
  assign lch  = {pos_r, 1'b1};
  assign rch  = lch + (CW+1)'(1);
  assign less = cmp_a[EW-1:CW] < cmp_b[EW-1:CW];

  always_ff @(posedge clk) begin
    if (we) begin
      heap_mem[wa]        <= wd;
      slot_mem[wd[CW-1:0]] <= wa;
    end
    rda_q <= heap_mem[ra];
    rdb_q <= heap_mem[rb];
    rds_q <= slot_mem[cmd.cell_id];
  end

  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    cpos_nxt  = cpos_r;
    ent_nxt   = ent_r;
    top_nxt   = top_r;
    child_nxt = child_r;
    done_nxt  = 1'b0;
    ra        = '0;
    rb        = '0;
    we        = 1'b0;
    wa        = pos_r;
    wd        = ent_r;
    cmp_a     = ent_r;
    cmp_b     = rda_q;
    unique case (st_r)
      H_IDLE: begin
        if (cmd.valid) begin
          case (cmd.op)
            gafm_pkg::HOP_PUSH: begin
              pos_nxt = cnt_r[CW-1:0];
              cnt_nxt = cnt_r + (CW+1)'(1);
              ent_nxt = cmd.entry;
              st_nxt  = H_SU_RD;
            end
            gafm_pkg::HOP_POP: st_nxt = H_P_RD;
            gafm_pkg::HOP_DEC: begin
              ent_nxt = cmd.entry;
              st_nxt  = H_DK_RH;
            end
            default: cnt_nxt = '0;
          endcase
        end
      end
      H_SU_RD: begin
        ra = par;
        if (pos_r == '0) begin
          we       = 1'b1;
          done_nxt = 1'b1;
          st_nxt   = H_IDLE;
        end else begin
          st_nxt = H_SU_CMP;
        end
      end
      H_SU_CMP: begin
        cmp_a = ent_r;
        cmp_b = rda_q;
        we    = 1'b1;
        if (less) begin
          wd      = rda_q;
          pos_nxt = par;
          st_nxt  = H_SU_RD;
        end else begin
          done_nxt = 1'b1;
          st_nxt   = H_IDLE;
        end
      end
      H_P_RD: begin
        ra     = '0;
        rb     = CW'(cnt_r - (CW+1)'(1));
        st_nxt = H_P_LD;
      end
      H_P_LD: begin
        top_nxt = rda_q;
        cnt_nxt = cnt_r - (CW+1)'(1);
        if (cnt_r == (CW+1)'(1)) begin
          done_nxt = 1'b1;
          st_nxt   = H_IDLE;
        end else begin
          ent_nxt = rdb_q;
          pos_nxt = '0;
          st_nxt  = H_SD_RD;
        end
      end
      H_SD_RD: begin
        ra = lch[CW-1:0];
        rb = rch[CW-1:0];
        if (lch >= cnt_r) begin
          we       = 1'b1;
          done_nxt = 1'b1;
          st_nxt   = H_IDLE;
        end else begin
          st_nxt = H_SD_SEL;
        end
      end
      H_SD_SEL: begin
        cmp_a = rdb_q;
        cmp_b = rda_q;
        if (rch < cnt_r && less) begin
          child_nxt = rdb_q;
          cpos_nxt  = rch[CW-1:0];
        end else begin
          child_nxt = rda_q;
          cpos_nxt  = lch[CW-1:0];
        end
        st_nxt = H_SD_CMP;
      end
      H_SD_CMP: begin
        cmp_a = child_r;
        cmp_b = ent_r;
        we    = 1'b1;
        if (less) begin
          wd      = child_r;
          pos_nxt = cpos_r;
          st_nxt  = H_SD_RD;
        end else begin
          done_nxt = 1'b1;
          st_nxt   = H_IDLE;
        end
      end
      H_DK_RH: begin
        ra      = rds_q;
        pos_nxt = rds_q;
        st_nxt  = H_DK_LD;
      end
      H_DK_LD: begin
        // Keep the sequence number and cell, take the lowered f.
        ent_nxt = {ent_r[EW-1:EW-gafm_pkg::F_W], rda_q[EW-gafm_pkg::F_W-1:0]};
        st_nxt  = H_SU_RD;
      end
      default: st_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= H_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    pos_r   <= pos_nxt;
    cpos_r  <= cpos_nxt;
    ent_r   <= ent_nxt;
    top_r   <= top_nxt;
    child_r <= child_nxt;
  end

  assign sts.busy  = (st_r != H_IDLE);
  assign sts.done  = done_r;
  assign sts.empty = (cnt_r == '0);
  assign sts.top   = top_r;

endmodule

`default_nettype wire

// ===== hdl/grid_astar_first_move.sv =====
// Top level of the grid A* first-move search block: obstacle map, per-cell
// search memories and the search sequencer. Uses gafm_pkg and gafm_heap.
`timescale 1ns / 1ps
`default_nettype none

// The block holds a 32 x 32 obstacle map and runs A* searches over it with
// four neighbors, unit step cost and a Manhattan heuristic. An item with
// opcode 0 clears the map, opcode 1 writes one cell, opcode 2 searches from
// (cell_x, cell_y) to (goal_x, goal_y) and returns one result; opcode 3 is
// ignored. A map clear sweeps the map one cell per cycle, and the same sweep
// runs after reset, during which no item is accepted. A search first sweeps
// the search marks, then for each expanded cell looks at each neighbor in
// turn, skipping those off the grid, with a heap update when the neighbor is
// pushed or its key is lowered; each heap push, pop or key decrease walks the
// heap one level at a time through the single key comparator. The input is
// not ready while an operation is in progress; a finished result waits in
// the output register until it is taken, and only a later search result has
// to wait behind it.
module grid_astar_first_move (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [4:0]  in_cell_x,
  input  wire logic [4:0]  in_cell_y,
  input  wire logic        in_blocked,
  input  wire logic [4:0]  in_goal_x,
  input  wire logic [4:0]  in_goal_y,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_found,
  output logic [2:0]       out_first_move,
  output logic [9:0]       out_path_length,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [5:0]  cfg_wdata
);

  localparam logic [3:0] S_CLRMAP = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CLRMK  = 4'd2;
  localparam logic [3:0] S_INIT   = 4'd3;
  localparam logic [3:0] S_HWAIT  = 4'd4;
  localparam logic [3:0] S_NEXT   = 4'd5;
  localparam logic [3:0] S_POP    = 4'd6;
  localparam logic [3:0] S_PWAIT  = 4'd7;
  localparam logic [3:0] S_CUR    = 4'd8;
  localparam logic [3:0] S_CUR2   = 4'd9;
  localparam logic [3:0] S_NRD    = 4'd10;
  localparam logic [3:0] S_NCHK   = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  localparam int CW  = gafm_pkg::CELL_W;
  localparam int XW  = gafm_pkg::COORD_W;
  localparam int GW  = gafm_pkg::G_W;
  localparam int FW  = gafm_pkg::F_W;
  localparam int DW  = gafm_pkg::DIM_W;
  localparam int HW  = gafm_pkg::H_W;
  localparam int EW  = gafm_pkg::ENT_W;
  localparam logic [DW-1:0] SIDE = DW'(gafm_pkg::GRID_SIDE);

  // Per-cell memories: obstacle map, search mark, best cost, first step.
  logic          map_mem  [gafm_pkg::NCELLS];
  logic [1:0]    mark_mem [gafm_pkg::NCELLS];
  logic [GW-1:0] g_mem    [gafm_pkg::NCELLS];
  logic [1:0]    dir_mem  [gafm_pkg::NCELLS];
  logic          map_q;
  logic [1:0]    mark_q;
  logic [GW-1:0] g_q;
  logic [1:0]    dir_q;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [XW-1:0] sx_r, sy_r, gx_r, gy_r;
  logic [XW-1:0] sx_nxt, sy_nxt, gx_nxt, gy_nxt;
  logic [DW-1:0] wid_r, hgt_r;
  logic [gafm_pkg::SEQ_W-1:0] seq_r, seq_nxt;
  logic [CW-1:0] cur_r, cur_nxt;
  logic [GW-1:0] gcur_r, gcur_nxt;
  logic          cstart_r, cstart_nxt;
  logic [1:0]    cdir_r, cdir_nxt;
  logic [1:0]    d_r, d_nxt;
  logic [CW-1:0] nc_r, nc_nxt;
  logic [HW-1:0] nh_r, nh_nxt;
  logic          res_found_r, res_found_nxt;
  logic [2:0]    res_move_r, res_move_nxt;
  logic [GW-1:0] res_len_r, res_len_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          found_r, found_nxt;
  logic [2:0]    move_r, move_nxt;
  logic [GW-1:0] len_r, len_nxt;

  // Memory port controls.
  logic [CW-1:0] rd_addr, map_wa, cw_addr;
  logic          map_we, map_wd, mk_we, gd_we;
  logic [1:0]    mk_wd, dir_wd;
  logic [GW-1:0] g_wd;

  gafm_pkg::heap_cmd_t hp_cmd;
  gafm_pkg::heap_sts_t hp_sts;

  // Neighbor of the current cell in direction d_r.
  logic [DW-1:0] cx, cy, nx, ny, wlim, hlim;
  logic          nok, inb;
  logic [GW-1:0] gnew;
  logic [FW-1:0] fnew;
  logic [1:0]    fdir;
  logic [CW-1:0] topcell;
  logic [HW-1:0] hcur;
  logic          accept;

  assign accept = in_valid && in_ready;
  assign wlim   = (wid_r > SIDE) ? SIDE : wid_r;
  assign hlim   = (hgt_r > SIDE) ? SIDE : hgt_r;
  assign cx     = {1'b0, cur_r[XW-1:0]};
  assign cy     = {1'b0, cur_r[CW-1:XW]};

  always_comb begin
    nx  = cx;
    ny  = cy;
    nok = 1'b1;
    case (d_r)
      2'd0: nx = cx + DW'(1);
      2'd1: begin
        nx  = cx - DW'(1);
        nok = (cx != '0);
      end
      2'd2: ny = cy + DW'(1);
      default: begin
        ny  = cy - DW'(1);
        nok = (cy != '0);
      end
    endcase
  end

  // The first step of a new path is inherited from the current cell, whose
  // direction is held in cdir_r because the memory port then reads the neighbor.
  assign inb     = nok && (nx < wlim) && (ny < hlim);
  assign gnew    = gcur_r + GW'(1);
  assign fnew    = {1'b0, gnew} + FW'(nh_r);
  assign fdir    = cstart_r ? d_r : cdir_r;
  assign topcell = hp_sts.top[CW-1:0];
  assign hcur    = gafm_pkg::manhattan(topcell[XW-1:0], topcell[CW-1:XW], gx_r, gy_r);

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    if (mk_we) begin
      mark_mem[cw_addr] <= mk_wd;
    end
    if (gd_we) begin
      g_mem[cw_addr]   <= g_wd;
      dir_mem[cw_addr] <= dir_wd;
    end
    map_q  <= map_mem[rd_addr];
    mark_q <= mark_mem[rd_addr];
    g_q    <= g_mem[rd_addr];
    dir_q  <= dir_mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    gx_nxt        = gx_r;
    gy_nxt        = gy_r;
    seq_nxt       = seq_r;
    cur_nxt       = cur_r;
    gcur_nxt      = gcur_r;
    cstart_nxt    = cstart_r;
    cdir_nxt      = cdir_r;
    d_nxt         = d_r;
    nc_nxt        = nc_r;
    nh_nxt        = nh_r;
    res_found_nxt = res_found_r;
    res_move_nxt  = res_move_r;
    res_len_nxt   = res_len_r;
    rd_addr       = cur_r;
    map_we        = 1'b0;
    map_wa        = cnt_r;
    map_wd        = 1'b0;
    mk_we         = 1'b0;
    gd_we         = 1'b0;
    cw_addr       = nc_r;
    mk_wd         = gafm_pkg::MK_OPEN;
    g_wd          = gnew;
    dir_wd        = fdir;
    hp_cmd        = '0;
    unique case (state_r)
      S_CLRMAP: begin
        map_we  = 1'b1;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (in_opcode)
            gafm_pkg::OP_CLEAR: state_nxt = S_CLRMAP;
            gafm_pkg::OP_WRITE: begin
              map_we = 1'b1;
              map_wa = {in_cell_y, in_cell_x};
              map_wd = in_blocked;
            end
            gafm_pkg::OP_SEARCH: begin
              sx_nxt     = in_cell_x;
              sy_nxt     = in_cell_y;
              gx_nxt     = in_goal_x;
              gy_nxt     = in_goal_y;
              hp_cmd.valid = 1'b1;
              hp_cmd.op  = gafm_pkg::HOP_CLR;
              state_nxt  = S_CLRMK;
            end
            default: ;
          endcase
        end
      end
      S_CLRMK: begin
        mk_we   = 1'b1;
        cw_addr = cnt_r;
        mk_wd   = gafm_pkg::MK_UNSEEN;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == '1) begin
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cw_addr      = {sy_r, sx_r};
        mk_we        = 1'b1;
        gd_we        = 1'b1;
        g_wd         = '0;
        dir_wd       = '0;
        hp_cmd.valid = 1'b1;
        hp_cmd.op    = gafm_pkg::HOP_PUSH;
        hp_cmd.entry = {FW'(gafm_pkg::manhattan(sx_r, sy_r, gx_r, gy_r)),
                        gafm_pkg::SEQ_W'(0), sy_r, sx_r};
        seq_nxt      = gafm_pkg::SEQ_W'(1);
        // Direction 3 makes the next step a pop.
        d_nxt        = 2'd3;
        state_nxt    = S_HWAIT;
      end
      S_HWAIT: begin
        if (hp_sts.done) begin
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (d_r == 2'd3) begin
          state_nxt = S_POP;
        end else begin
          d_nxt     = d_r + 2'd1;
          state_nxt = S_NRD;
        end
      end
      S_POP: begin
        if (hp_sts.empty) begin
          res_found_nxt = 1'b0;
          res_move_nxt  = gafm_pkg::MOVE_NONE;
          res_len_nxt   = '0;
          state_nxt     = S_DONE;
        end else begin
          hp_cmd.valid = 1'b1;
          hp_cmd.op    = gafm_pkg::HOP_POP;
          state_nxt    = S_PWAIT;
        end
      end
      S_PWAIT: begin
        if (hp_sts.done) begin
          cur_nxt    = topcell;
          gcur_nxt   = GW'(hp_sts.top[EW-1:EW-FW] - FW'(hcur));
          cstart_nxt = (topcell == {sy_r, sx_r});
          state_nxt  = S_CUR;
        end
      end
      S_CUR: begin
        rd_addr   = cur_r;
        state_nxt = S_CUR2;
      end
      S_CUR2: begin
        mk_we    = 1'b1;
        cw_addr  = cur_r;
        mk_wd    = gafm_pkg::MK_CLOSED;
        cdir_nxt = dir_q;
        if (cur_r == {gy_r, gx_r}) begin
          res_found_nxt = 1'b1;
          res_move_nxt  = cstart_r ? gafm_pkg::MOVE_NONE : {1'b0, dir_q};
          res_len_nxt   = gcur_r;
          state_nxt     = S_DONE;
        end else begin
          d_nxt     = 2'd0;
          state_nxt = S_NRD;
        end
      end
      S_NRD: begin
        rd_addr = {ny[XW-1:0], nx[XW-1:0]};
        nc_nxt  = {ny[XW-1:0], nx[XW-1:0]};
        nh_nxt  = gafm_pkg::manhattan(nx[XW-1:0], ny[XW-1:0], gx_r, gy_r);
        state_nxt = inb ? S_NCHK : S_NEXT;
      end
      S_NCHK: begin
        hp_cmd.entry   = {fnew, seq_r, nc_r};
        hp_cmd.cell_id = nc_r;
        if (map_q || mark_q == gafm_pkg::MK_CLOSED) begin
          state_nxt = S_NEXT;
        end else if (mark_q == gafm_pkg::MK_UNSEEN) begin
          mk_we        = 1'b1;
          gd_we        = 1'b1;
          hp_cmd.valid = 1'b1;
          hp_cmd.op    = gafm_pkg::HOP_PUSH;
          seq_nxt      = seq_r + gafm_pkg::SEQ_W'(1);
          state_nxt    = S_HWAIT;
        end else if (gnew < g_q) begin
          gd_we        = 1'b1;
          hp_cmd.valid = 1'b1;
          hp_cmd.op    = gafm_pkg::HOP_DEC;
          state_nxt    = S_HWAIT;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register: loaded when a search finishes and the slot is free.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    found_nxt     = found_r;
    move_nxt      = move_r;
    len_nxt       = len_r;
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_valid_nxt = 1'b1;
      found_nxt     = res_found_r;
      move_nxt      = res_move_r;
      len_nxt       = res_len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLRMAP;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      wid_r       <= DW'(16);
      hgt_r       <= DW'(16);
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_index == gafm_pkg::REG_GRID_HEIGHT) begin
          hgt_r <= cfg_wdata;
        end else begin
          wid_r <= cfg_wdata;
        end
      end
    end
    sx_r        <= sx_nxt;
    sy_r        <= sy_nxt;
    gx_r        <= gx_nxt;
    gy_r        <= gy_nxt;
    seq_r       <= seq_nxt;
    cur_r       <= cur_nxt;
    gcur_r      <= gcur_nxt;
    cstart_r    <= cstart_nxt;
    cdir_r      <= cdir_nxt;
    d_r         <= d_nxt;
    nc_r        <= nc_nxt;
    nh_r        <= nh_nxt;
    res_found_r <= res_found_nxt;
    res_move_r  <= res_move_nxt;
    res_len_r   <= res_len_nxt;
    found_r     <= found_nxt;
    move_r      <= move_nxt;
    len_r       <= len_nxt;
  end

  gafm_heap u_heap (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (hp_cmd),
    .sts   (hp_sts)
  );

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_found       = found_r;
  assign out_first_move  = move_r;
  assign out_path_length = len_r;

  // The heap is never mid-operation while a new item can be taken.
  a_idle_heap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !hp_sts.busy)
    else $error("heap busy while input ready");

  // Heap completions only arrive while the sequencer waits for them.
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    hp_sts.done |-> (state_r == S_HWAIT || state_r == S_PWAIT))
    else $error("unexpected heap completion");

  // A failed search reports no move and no length.
  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_first_move == gafm_pkg::MOVE_NONE &&
                                   out_path_length == '0))
    else $error("not-found result carries a move or length");

  // A fresh result is loaded only from the finishing state.
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == S_DONE)
    else $error("result appeared outside search completion");

endmodule

`default_nettype wire
